FILE: hdl/mfrc_pkg.sv
// Shared types, constants and the byte-wide CRC function for the mesh frame
// receive checker. No dependencies; used by mesh_frame_receive_checker_core.
`timescale 1ns / 1ps
`default_nettype none

package mfrc_pkg;

  // Frame layout
  localparam int HEADER_BYTES  = 9;
  localparam int CRC_BYTES     = 2;
  localparam int MAX_FRAME_DEF = 255;
  localparam int IDX_W         = 9;          // byte index, saturates at 256
  localparam int IDX_SAT       = 256;

  // CRC-16/XMODEM
  localparam logic [15:0] CRC_POLY = 16'h1021;
  localparam logic [15:0] CRC_INIT = 16'h0000;
  localparam logic [15:0] CRC_TOP  = 16'h8000;

  // Configuration port
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 32;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_NODE_ID      = 1'b0,
    REG_BROADCAST_ID = 1'b1
  } cfg_reg_t;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_NOT_ADDR = 3'd1,
    ST_CRC_ERR  = 3'd2,
    ST_SHORT    = 3'd3,
    ST_LONG     = 3'd4
  } frame_status_t;

  typedef struct packed {
    logic [7:0] rx_byte;
    logic       frame_end;
  } rx_word_t;

  typedef struct packed {
    logic          payload_valid;
    logic [7:0]    payload_byte;
    logic          done_res;
    frame_status_t status;
    logic [7:0]    hops;
    logic [31:0]   sender;
    logic [31:0]   destination;
    logic [7:0]    payload_count;
  } res_word_t;

  // One byte through the MSB-first CRC, eight shift steps unrolled
  function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int k = 0; k < 8; k++) begin
      if ((c & CRC_TOP) != 16'h0000) begin
        c = {c[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

`default_nettype wire

FILE: hdl/mesh_frame_receive_checker_core.sv
// Top level of the mesh frame receive checker: header capture, CRC-16,
// two-byte payload delay, status and a two-entry result buffer. Uses mfrc_pkg.
`timescale 1ns / 1ps
`default_nettype none

// Takes a received frame one byte per word (frame_end on the last byte) and
// accepts one word every clock cycle while rx_stall is low. All work for a
// byte is done in one pass from the frame state to the result register, so
// a result is registered there, or in the skid register while the output
// stalls; the CRC unit is unrolled over the whole byte, which is what allows
// the one-byte-per-cycle rate. A payload byte comes out two bytes after it
// arrives, once it is known not to be CRC. Bytes that release nothing and
// do not end a frame give no result word. A skid register behind the result
// register lets input keep flowing for one result while the output side
// stalls; rx_stall rises only when both are full. Checks run in the order
// length, address, CRC. Configuration writes take effect on the next byte.
module mesh_frame_receive_checker_core #(
  parameter int MAX_FRAME = mfrc_pkg::MAX_FRAME_DEF
) (
  input  wire                              clk,
  input  wire                              rst,
  // configuration
  input  wire                              cfg_we,
  input  wire [mfrc_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire [mfrc_pkg::CFG_DATA_W-1:0]   cfg_data,
  // byte input
  input  wire                              rx_valid,
  output logic                             rx_stall,
  input  wire mfrc_pkg::rx_word_t          rx_word,
  // results
  output logic                             res_valid,
  input  wire                              res_stall,
  output mfrc_pkg::res_word_t              res_word
);

  import mfrc_pkg::*;

  localparam logic [IDX_W-1:0] MIN_LEN_IDX = IDX_W'(HEADER_BYTES + CRC_BYTES);
  localparam logic [IDX_W-1:0] SHORT_IDX   = IDX_W'(HEADER_BYTES + CRC_BYTES - 1);
  localparam logic [IDX_W-1:0] MAX_IDX     = IDX_W'(MAX_FRAME);
  localparam logic [IDX_W-1:0] SAT_IDX     = IDX_W'(IDX_SAT);

  // configuration registers
  logic [31:0] node_id;
  logic [31:0] broadcast_id;

  // frame state
  logic [IDX_W-1:0] byte_index;
  logic [15:0]      crc_reg;
  logic [7:0]       dly_new;
  logic [7:0]       dly_old;
  logic [7:0]       hop_reg;
  logic [31:0]      sender_reg;
  logic [31:0]      dest_reg;

  // result buffer
  logic      skid_valid;
  res_word_t skid_word;

  logic             rx_acc;
  logic             addressed;
  logic             release_byte;
  logic [15:0]      crc_next;
  logic [15:0]      rx_crc;
  logic [7:0]       hop_next;
  logic [31:0]      sender_next;
  logic [31:0]      dest_next;
  logic [IDX_W-1:0] idx_next;
  logic [IDX_W-1:0] cnt_full;
  res_word_t        new_word;
  logic             new_valid;

  assign rx_stall = skid_valid;
  assign rx_acc   = rx_valid && !rx_stall;

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      node_id      <= '0;
      broadcast_id <= '1;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_NODE_ID:      node_id      <= cfg_data;
        REG_BROADCAST_ID: broadcast_id <= cfg_data;
        default: ;
      endcase
    end
  end

  // address match and payload release use the destination seen so far
  assign addressed    = (dest_reg == node_id) || (dest_reg == broadcast_id);
  assign release_byte = (byte_index >= MIN_LEN_IDX) && (byte_index < MAX_IDX) && addressed;

  // CRC runs two bytes behind the input
  assign crc_next = (byte_index >= IDX_W'(CRC_BYTES)) ? crc16_byte(crc_reg, dly_old) : crc_reg;
  assign rx_crc   = {rx_word.rx_byte, dly_new};

  assign idx_next = (byte_index == SAT_IDX) ? byte_index : byte_index + 1'b1;
  assign cnt_full = byte_index - SHORT_IDX;

  // header capture, little-endian ids
  always_comb begin
    hop_next    = hop_reg;
    sender_next = sender_reg;
    dest_next   = dest_reg;
    case (byte_index)
      9'd0: hop_next           = rx_word.rx_byte;
      9'd1: sender_next[7:0]   = rx_word.rx_byte;
      9'd2: sender_next[15:8]  = rx_word.rx_byte;
      9'd3: sender_next[23:16] = rx_word.rx_byte;
      9'd4: sender_next[31:24] = rx_word.rx_byte;
      9'd5: dest_next[7:0]     = rx_word.rx_byte;
      9'd6: dest_next[15:8]    = rx_word.rx_byte;
      9'd7: dest_next[23:16]   = rx_word.rx_byte;
      9'd8: dest_next[31:24]   = rx_word.rx_byte;
      default: ;
    endcase
  end

  // result word for the byte being accepted
  always_comb begin
    new_word               = '0;
    new_word.payload_valid = release_byte;
    new_word.payload_byte  = release_byte ? dly_old : 8'h00;
    if (rx_word.frame_end) begin
      new_word.done_res    = 1'b1;
      new_word.hops        = hop_next;
      new_word.sender      = sender_next;
      new_word.destination = dest_next;
      if (byte_index < SHORT_IDX) begin
        new_word.status = ST_SHORT;
      end else if (byte_index >= MAX_IDX) begin
        new_word.status = ST_LONG;
      end else begin
        new_word.payload_count = cnt_full[7:0];
        if (!addressed) begin
          new_word.status = ST_NOT_ADDR;
        end else if (crc_next != rx_crc) begin
          new_word.status = ST_CRC_ERR;
        end else begin
          new_word.status = ST_OK;
        end
      end
    end
  end

  assign new_valid = rx_acc && (release_byte || rx_word.frame_end);

  // frame state update; everything clears after the last byte
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_index <= '0;
      crc_reg    <= CRC_INIT;
      dly_new    <= '0;
      dly_old    <= '0;
      hop_reg    <= '0;
      sender_reg <= '0;
      dest_reg   <= '0;
    end else if (rx_acc) begin
      if (rx_word.frame_end) begin
        byte_index <= '0;
        crc_reg    <= CRC_INIT;
        dly_new    <= '0;
        dly_old    <= '0;
        hop_reg    <= '0;
        sender_reg <= '0;
        dest_reg   <= '0;
      end else begin
        byte_index <= idx_next;
        crc_reg    <= crc_next;
        dly_new    <= rx_word.rx_byte;
        dly_old    <= dly_new;
        hop_reg    <= hop_next;
        sender_reg <= sender_next;
        dest_reg   <= dest_next;
      end
    end
  end

  // result register with skid stage
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (res_valid && res_stall) begin
      if (new_valid) begin
        skid_valid <= 1'b1;
      end
    end else if (skid_valid) begin
      res_valid  <= 1'b1;
      skid_valid <= 1'b0;
    end else begin
      res_valid <= new_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_stall) begin
      if (new_valid) begin
        skid_word <= new_word;
      end
    end else if (skid_valid) begin
      res_word <= skid_word;
    end else if (new_valid) begin
      res_word <= new_word;
    end
  end

  // checks
  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> res_valid)
    else $error("skid holds a word while the result register is empty");

  a_end_clears: assert property (@(posedge clk) disable iff (rst)
    rx_acc && rx_word.frame_end |=> (byte_index == '0) && (crc_reg == CRC_INIT))
    else $error("frame state not cleared after last byte");

  a_word_has_content: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> (res_word.payload_valid || res_word.done_res))
    else $error("result word carries neither payload nor status");

  a_len_err_count: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_word.done_res &&
    (res_word.status == ST_SHORT || res_word.status == ST_LONG)
    |-> (res_word.payload_count == 8'h00))
    else $error("payload count set on a length error");

endmodule

`default_nettype wire
